// ===== src/epsv_pkg.sv =====
`timescale 1ns / 1ps
package epsv_pkg;

    // Time format: signed fixed point, 1/64 ns per LSB.
    localparam int TIME_FRAC_BITS = 6;
    localparam int NS             = 1 << TIME_FRAC_BITS;

    // Tot limits of the slewing correction.
    localparam int TOT_SLEW_LO = 2 * NS;
    localparam int TOT_FINE_HI = 15 * NS;
    localparam int TOT_CLAMP   = 40 * NS;
    localparam int TOT_SLEW_HI = 60 * NS;

    // Width of the clamped tot that feeds the quadratic.
    localparam int TS_W = $clog2(TOT_CLAMP + 1);

    // Slew coefficients in Q.20.
    localparam longint SLEW_C0 = 6689915;
    localparam longint SLEW_C1 = 317719;
    localparam longint SLEW_C2 = 3752;
    localparam longint SLEW_C3 = 1258291;
    localparam int     C1_W    = 19;
    localparam int     C2_W    = 12;

    localparam int     SLEW_SHIFT = 20 + TIME_FRAC_BITS;
    localparam longint SLEW_K0    = SLEW_C0 * NS * NS + (64'sd1 <<< (SLEW_SHIFT - 1));
    localparam longint SLEW_FINE  = ((SLEW_C3 <<< TIME_FRAC_BITS) + (64'sd1 <<< 19)) >>> 20;

    localparam int P1_W   = C1_W + TS_W;
    localparam int SQ_W   = 2 * TS_W;
    localparam int P2_W   = C2_W + SQ_W;
    localparam int NUM_W  = 48;
    localparam int SLEW_W = 16;

    typedef logic [3:0] t_prio;

    localparam t_prio PRIO_TABLE [16] = '{
        4'd0, 4'd4, 4'd5, 4'd10, 4'd2, 4'd7, 4'd11, 4'd13,
        4'd1, 4'd12, 4'd6, 4'd14, 4'd3, 4'd8, 4'd9, 4'd15
    };

    typedef enum logic {
        CFG_WINDOW   = 1'b0,
        CFG_MIN_PRIO = 1'b1
    } t_cfg_idx;

    // One classified hit as it travels from the front to the back.
    typedef struct packed {
        t_prio              prio;   // priority, zero when outside the raw window
        logic signed [32:0] delta;  // hit time minus reference time
        logic signed [31:0] tot;    // time over threshold, saturated
        logic               last;
    } t_hit_class;

    // One event result, first field in the highest bits.
    typedef struct packed {
        logic signed [31:0] largest_tot_time;
        logic signed [31:0] largest_tot;
        logic signed [39:0] tot_sum;
        logic [7:0]         hit_total;
        t_prio              best_priority;
        logic               veto_candidate;
    } t_result;

endpackage

// ===== src/epsv_front.sv =====
`timescale 1ns / 1ps
module epsv_front
    import epsv_pkg::*;
(
    input  logic [15:0]        i_window,
    input  logic signed [31:0] i_hit_time,
    input  logic signed [31:0] i_ref_time,
    input  logic signed [31:0] i_leading_low,
    input  logic signed [31:0] i_trailing_low,
    input  logic [3:0]         i_edge_mask,
    input  logic               i_last_hit,
    output t_hit_class         o_class
);

    logic signed [32:0] w_delta;
    logic [32:0]        w_abs;
    logic signed [32:0] w_tot_raw;
    logic signed [31:0] w_tot;
    logic               w_in_win;

    // Raw time relative to the reference and its magnitude.
    always_comb begin
        w_delta  = 33'(i_hit_time) - 33'(i_ref_time);
        w_abs    = w_delta[32] ? (~w_delta + 33'd1) : w_delta;
        w_in_win = w_abs < {17'd0, i_window};
    end

    // Time over threshold exists only when both low edges were seen.
    always_comb begin
        w_tot_raw = 33'(i_trailing_low) - 33'(i_leading_low);
        if (i_leading_low == 32'sd0 || i_trailing_low == 32'sd0) begin
            w_tot = 32'sd0;
        end else if (w_tot_raw[32] != w_tot_raw[31]) begin
            w_tot = w_tot_raw[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_tot = w_tot_raw[31:0];
        end
    end

    always_comb begin
        o_class.prio  = w_in_win ? PRIO_TABLE[i_edge_mask] : 4'd0;
        o_class.delta = w_delta;
        o_class.tot   = w_tot;
        o_class.last  = i_last_hit;
    end

endmodule

// ===== src/epsv_fifo.sv =====
`timescale 1ns / 1ps
module epsv_fifo
    import epsv_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_hit_class i_data,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_hit_class o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_hit_class       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on a lone push");

endmodule

// ===== src/epsv_back.sv =====
`timescale 1ns / 1ps
module epsv_back
    import epsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_window,
    input  t_prio       i_min_prio,
    input  logic        i_head_valid,
    input  t_hit_class  i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    // Pipeline advances whenever the result register can take a new value.
    logic w_adv;

    // Stage 1: clamped tot, region flags, first products.
    logic                    r_v1;
    t_hit_class              r_h1;
    logic                    r_quad1, r_fine1;
    logic [P1_W-1:0]         r_p1;
    logic [SQ_W-1:0]         r_sq;
    logic [TS_W-1:0]         w_ts;
    logic                    w_quad, w_fine;

    // Stage 2: coefficient times square.
    logic                    r_v2;
    t_hit_class              r_h2;
    logic                    r_quad2, r_fine2;
    logic [P1_W-1:0]         r_p1b;
    logic [P2_W-1:0]         r_p2;

    // Stage 3: slew value.
    logic                    r_v3;
    t_hit_class              r_h3;
    logic signed [SLEW_W-1:0] r_slew, n_slew;
    logic signed [NUM_W-1:0] w_num;
    logic signed [NUM_W-1:0] w_num_q;

    // Stage 4: corrected relative time.
    logic                    r_v4;
    t_hit_class              r_h4;
    logic signed [31:0]      r_ct, n_ct;
    logic signed [33:0]      w_ct_raw;

    // Event state.
    t_prio                   r_best, n_best;
    logic [7:0]              r_hits, n_hits;
    logic signed [39:0]      r_tot_acc, n_tot_acc;
    logic signed [31:0]      r_max_tot, n_max_tot;
    logic signed [31:0]      r_max_time, n_max_time;
    logic                    r_max_valid, n_max_valid;
    logic signed [40:0]      w_sum;
    logic [32:0]             w_abs_time;
    logic                    w_acc;

    t_result                 r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    assign w_adv    = !r_out_valid || i_ready;
    assign o_pop    = w_adv && i_head_valid;
    assign w_acc    = w_adv && r_v4;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        w_quad = i_head.tot inside {[TOT_SLEW_LO + 1 : TOT_SLEW_HI - 1]};
        w_fine = i_head.tot inside {[TOT_SLEW_LO + 1 : TOT_FINE_HI - 1]};
        if (i_head.tot >= TOT_CLAMP) begin
            w_ts = TS_W'(TOT_CLAMP);
        end else begin
            w_ts = i_head.tot[TS_W-1:0];
        end
    end

    always_comb begin
        w_num   = NUM_W'(SLEW_K0) - (NUM_W'(r_p1b) << TIME_FRAC_BITS) + NUM_W'(r_p2);
        w_num_q = w_num >>> SLEW_SHIFT;
        n_slew  = (r_quad2 ? SLEW_W'(w_num_q) : '0)
                + (r_fine2 ? SLEW_W'(SLEW_FINE) : '0);
    end

    always_comb begin
        w_ct_raw = 34'(r_h3.delta) - 34'(r_slew);
        if (w_ct_raw > 34'sh0_7FFF_FFFF) begin
            n_ct = 32'sh7FFF_FFFF;
        end else if (w_ct_raw < -34'sh0_8000_0000) begin
            n_ct = 32'sh8000_0000;
        end else begin
            n_ct = w_ct_raw[31:0];
        end
    end

    // Event accumulation and result formation.
    always_comb begin
        n_best      = (r_h4.prio > r_best) ? r_h4.prio : r_best;
        n_hits      = r_hits + {7'd0, (r_hits != 8'hFF)};
        w_sum       = 41'(r_tot_acc) + 41'(r_h4.tot);
        if (w_sum[40] != w_sum[39]) begin
            n_tot_acc = w_sum[40] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
        end else begin
            n_tot_acc = w_sum[39:0];
        end
        n_max_tot   = r_max_tot;
        n_max_time  = r_max_time;
        n_max_valid = r_max_valid;
        if (r_h4.tot >= r_max_tot) begin
            n_max_tot   = r_h4.tot;
            n_max_time  = r_ct;
            n_max_valid = 1'b1;
        end
        w_abs_time = n_max_time[31] ? (~33'(n_max_time) + 33'd1) : 33'(n_max_time);

        n_out.veto_candidate   = (n_best >= i_min_prio) && n_max_valid
                               && (w_abs_time < {17'd0, i_window});
        n_out.best_priority    = n_best;
        n_out.hit_total        = n_hits;
        n_out.tot_sum          = n_tot_acc;
        n_out.largest_tot      = n_max_tot;
        n_out.largest_tot_time = n_max_valid ? n_max_time : 32'sd0;
        n_out_valid            = w_acc && r_h4.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            r_best      <= '0;
            r_hits      <= '0;
            r_tot_acc   <= '0;
            r_max_tot   <= '0;
            r_max_time  <= '0;
            r_max_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= i_head_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= n_out_valid;
            if (r_v4) begin
                if (r_h4.last) begin
                    r_best      <= '0;
                    r_hits      <= '0;
                    r_tot_acc   <= '0;
                    r_max_tot   <= '0;
                    r_max_time  <= '0;
                    r_max_valid <= 1'b0;
                end else begin
                    r_best      <= n_best;
                    r_hits      <= n_hits;
                    r_tot_acc   <= n_tot_acc;
                    r_max_tot   <= n_max_tot;
                    r_max_time  <= n_max_time;
                    r_max_valid <= n_max_valid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h1    <= i_head;
            r_quad1 <= w_quad;
            r_fine1 <= w_fine;
            r_p1    <= P1_W'(SLEW_C1) * P1_W'(w_ts);
            r_sq    <= SQ_W'(w_ts) * SQ_W'(w_ts);
            r_h2    <= r_h1;
            r_quad2 <= r_quad1;
            r_fine2 <= r_fine1;
            r_p1b   <= r_p1;
            r_p2    <= P2_W'(SLEW_C2) * P2_W'(r_sq);
            r_h3    <= r_h2;
            r_slew  <= n_slew;
            r_h4    <= r_h3;
            r_ct    <= n_ct;
            r_out   <= n_out;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_h4.last) |=> (r_hits == 8'd0 && !r_max_valid))
        else $error("event state not cleared after the last hit");

    a_result_counts_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_h4.last) |=> (r_out_valid && r_out.hit_total != 8'd0))
        else $error("result lost or carries no hits");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_v4) && $stable(r_hits)))
        else $error("pipeline moved while the result was stalled");

endmodule

// ===== src/edge_priority_slew_veto_unit.sv =====
`timescale 1ns / 1ps
// Edge-priority slew veto for detector hit events.
//
// Input stream: one transfer per hit. tdata carries, from the lowest bit up,
// hit_time[31:0], ref_time[63:32], leading_low[95:64], trailing_low[127:96],
// edge_mask[131:128] and four zero bits; tlast marks the last hit of an event.
// Every event must carry at least one hit.
// Output stream: one transfer per event, after its last hit, with veto_candidate,
// best_priority, hit_total, tot_sum, largest_tot and largest_tot_time.
// Configuration: a write with i_cfg_we high sets the coincidence window (index 0)
// or the minimum priority (index 1); write only while no event is in flight.
//
// Throughput is one hit per cycle while the receiver does not stall. The front
// classifies a hit in the cycle of its transfer and writes it to a small queue;
// the back pulls it through four stages (slew multiplier, then time correction),
// folds it into the event state and registers the event's result, which drives
// o_m_axis_tvalid.
// When the receiver stalls, the back freezes, the queue fills, and the input
// tready drops once the queue is full; nothing is lost.
// Reset (synchronous, active low) empties the queue and the pipeline, clears
// the event state and loads a 5 ns window and a minimum priority of nine.
module edge_priority_slew_veto_unit
    import epsv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // hit_time, ref_time, leading_low, trailing_low, edge_mask, zero pad
    input  logic [135:0] i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // veto_candidate, best_priority, hit_total, tot_sum, largest_tot,
    // largest_tot_time, zero pad
    output logic [119:0] o_m_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_window;
    t_prio       r_min_prio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= 16'd320;
            r_min_prio <= 4'd9;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW:   r_window   <= i_cfg_data;
                CFG_MIN_PRIO: r_min_prio <= i_cfg_data[3:0];
                default:      r_window   <= r_window;
            endcase
        end
    end

    t_hit_class w_class;
    t_hit_class w_head;
    logic       w_full;
    logic       w_push;
    logic       w_head_valid;
    logic       w_pop;
    t_result    w_result;

    assign o_s_axis_tready = !w_full;
    assign w_push          = i_s_axis_tvalid && !w_full;

    // The front looks only at the raw fields of the current transfer and the window.
    epsv_front u_front (
        .i_window       (r_window),
        .i_hit_time     (i_s_axis_tdata[31:0]),
        .i_ref_time     (i_s_axis_tdata[63:32]),
        .i_leading_low  (i_s_axis_tdata[95:64]),
        .i_trailing_low (i_s_axis_tdata[127:96]),
        .i_edge_mask    (i_s_axis_tdata[131:128]),
        .i_last_hit     (i_s_axis_tlast),
        .o_class        (w_class)
    );

    epsv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_class),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_head)
    );

    epsv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window     (r_window),
        .i_min_prio   (r_min_prio),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_result     (w_result)
    );

    assign o_m_axis_tdata = {3'd0, w_result};

endmodule
